// ===== hdl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

	localparam int BlockBits = 128;
	localparam int KeyBits   = 128;
	localparam int WordBits  = 64;
	localparam int NumRounds = 10;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_KEY_HIGH = 2'd0,
		CFG_KEY_LOW  = 2'd1,
		CFG_IV_HIGH  = 2'd2,
		CFG_IV_LOW   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYLOAD,
		ST_ROUND,
		ST_DONE
	} core_state_t;

	// round control between sequencer and datapath
	typedef struct packed {
		logic       load;
		logic       step;
		logic       last;
	} rnd_ctrl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// next round constant
	function automatic logic [7:0] rcon_next(input logic [7:0] r);
		return xtime(r);
	endfunction

	// one key schedule step: 128-bit key in, next round key out
	function automatic logic [KeyBits-1:0] key_step(input logic [KeyBits-1:0] k,
			input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_column.sv =====
`default_nettype none
// Column unit: SubBytes on the four bytes of one shifted column, then
// optional MixColumns and the round key column. One column per cycle.
module aes_column (
	input  wire logic [31:0] col_in,
	input  wire logic        mix,
	input  wire logic [31:0] key_col,
	output logic      [31:0] col_out
);
	import aes_pkg::*;

	logic [7:0] a0, a1, a2, a3, all, m0, m1, m2, m3;

	always_comb begin
		a0  = sbox(col_in[31:24]);
		a1  = sbox(col_in[23:16]);
		a2  = sbox(col_in[15:8]);
		a3  = sbox(col_in[7:0]);
		all = a0 ^ a1 ^ a2 ^ a3;
		m0  = a0 ^ all ^ xtime(a0 ^ a1);
		m1  = a1 ^ all ^ xtime(a1 ^ a2);
		m2  = a2 ^ all ^ xtime(a2 ^ a3);
		m3  = a3 ^ all ^ xtime(a3 ^ a0);
		if (mix) begin
			col_out = {m0, m1, m2, m3} ^ key_col;
		end else begin
			col_out = {a0, a1, a2, a3} ^ key_col;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/aes_round_seq.sv =====
`default_nettype none
// Sequencer: key load, then ten rounds each of four column steps.
module aes_round_seq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       out_taken,
	output aes_pkg::rnd_ctrl_t              ctrl,
	output logic                            busy,
	output logic                            done,
	output logic [1:0]                      col,
	output logic [3:0]                      rnd
);
	import aes_pkg::*;

	core_state_t state_q, state_d;
	logic [1:0]  col_q;
	logic [3:0]  rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			// round zero while idle marks the key load cycle
			if (state_q == ST_IDLE) begin
				rnd_q <= '0;
			end else if (state_q == ST_KEYLOAD) begin
				col_q <= '0;
				rnd_q <= 4'd1;
			end else if (state_q == ST_ROUND) begin
				col_q <= col_q + 2'd1;
				if (col_q == 2'd3) begin
					rnd_q <= rnd_q + 4'd1;
				end
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl.load = 1'b0;
		ctrl.step = 1'b0;
		ctrl.last = (rnd_q == 4'(NumRounds));
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = ST_KEYLOAD;
				end
			end
			ST_KEYLOAD: state_d = ST_ROUND;
			ST_ROUND: begin
				ctrl.step = 1'b1;
				if (col_q == 2'd3 && rnd_q == 4'(NumRounds)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_taken) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign col  = col_q;
	assign rnd  = rnd_q;

endmodule
`default_nettype wire

// ===== hdl/aes128_cbc_encrypt.sv =====
`default_nettype none
// AES-128 CBC encryptor.
// Input stream s_axis: tdata carries plain_high in the low half and
// plain_low in the high half, tuser carries chain_restart. Output stream
// m_axis: tdata carries cipher_high low, cipher_low high.
// Configuration through cfg_we/cfg_index/cfg_data: key_high, key_low,
// iv_high, iv_low; write only while idle.
// A request goes through key load, then ten rounds of four column steps
// through a single column unit, with round keys generated on the fly
// alongside, before the result is valid. The next request is taken the
// cycle after the result has gone. The CBC chain value is the ciphertext
// of the previous block, so one block is in flight.
// The result stays in the output register while the receiver stalls; the
// next request is taken once the result has gone.
// Reset clears keys, IV and chain to zero.
module aes128_cbc_encrypt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [63:0]   cfg_data,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// [63:0] plain_high, [127:64] plain_low
	input  wire logic [127:0]  s_axis_tdata,
	// [0] chain_restart
	input  wire logic          s_axis_tuser,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// [63:0] cipher_high, [127:64] cipher_low
	output logic      [127:0]  m_axis_tdata
);
	import aes_pkg::*;

	logic [KeyBits-1:0]   key_q, rkey_q;
	logic [BlockBits-1:0] iv_q, chain_q, st_q, nxt_q;
	logic [7:0]           rc_q;
	rnd_ctrl_t            ctrl;
	logic                 busy, done, start;
	logic [1:0]           col;
	logic [3:0]           rnd;
	logic [31:0]          col_in, key_col, col_out;
	logic [BlockBits-1:0] plain, pre;

	assign s_axis_tready = !busy;
	assign start         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = done;
	assign m_axis_tdata  = {chain_q[63:0], chain_q[127:64]};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY_HIGH: key_q[127:64] <= cfg_data;
				CFG_KEY_LOW:  key_q[63:0]   <= cfg_data;
				CFG_IV_HIGH:  iv_q[127:64]  <= cfg_data;
				CFG_IV_LOW:   iv_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign plain = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign pre   = plain ^ (s_axis_tuser ? iv_q : chain_q) ^ key_q;

	aes_round_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.out_taken (m_axis_tready),
		.ctrl      (ctrl),
		.busy      (busy),
		.done      (done),
		.col       (col),
		.rnd       (rnd)
	);

	// shifted column c: row r from column (c+r) mod 4
	always_comb begin
		col_in = {st_q[127 - 32*col -: 8],
			st_q[119 - 32*(2'(col + 2'd1)) -: 8],
			st_q[111 - 32*(2'(col + 2'd2)) -: 8],
			st_q[103 - 32*(2'(col + 2'd3)) -: 8]};
		key_col = rkey_q[127 - 32*col -: 32];
	end

	aes_column u_col (
		.col_in  (col_in),
		.mix     (!ctrl.last),
		.key_col (key_col),
		.col_out (col_out)
	);

	// state, round key and chain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			st_q    <= '0;
			nxt_q   <= '0;
			rkey_q  <= '0;
			rc_q    <= 8'h01;
		end else begin
			if (ctrl.load) begin
				st_q   <= pre;
				rkey_q <= key_q;
				rc_q   <= 8'h01;
			end else if (busy && rnd == 4'd0) begin
				rkey_q <= key_step(rkey_q, rc_q);
				rc_q   <= rcon_next(rc_q);
			end else if (ctrl.step) begin
				nxt_q[127 - 32*col -: 32] <= col_out;
				if (col == 2'd3) begin
					st_q <= {nxt_q[127:32], col_out};
					if (ctrl.last) begin
						chain_q <= {nxt_q[127:32], col_out};
					end else begin
						rkey_q <= key_step(rkey_q, rc_q);
						rc_q   <= rcon_next(rc_q);
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> !s_axis_tready)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n) !(m_axis_tvalid && s_axis_tready))
		else $error("ready while result pending");

endmodule
`default_nettype wire

// ===== test/aes128_cbc_encrypt_test.sv =====
`default_nettype none
module aes128_cbc_encrypt_test;
	import aes_pkg::*;

	localparam int HalfPeriod = 6;
	localparam int CycleLimit = 2000000;
	localparam int DrainCycles = 60;
	localparam int RandomBlocks = 1900;

	// byte substitution table, row by row
	localparam logic [7:0] SubTable [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	// one directed step: either a register set-up or a plaintext block
	typedef struct {
		bit           is_setup;
		logic [127:0] key;
		logic [127:0] iv;
		logic [127:0] plain;
		logic         restart;
		bit           known;
		logic [127:0] cipher;
	} step_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_index = CFG_KEY_HIGH;
	logic [63:0]   cfg_data = '0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [127:0]  s_axis_tdata = '0;
	logic          s_axis_tuser = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [127:0]  m_axis_tdata;

	// mirror of the block's registers and chaining value
	logic [127:0]  key_q = '0;
	logic [127:0]  iv_q = '0;
	logic [127:0]  chain_q = '0;
	logic [127:0]  cipher_queue [$];

	int unsigned   send_idle_pct = 11;
	int unsigned   recv_idle_pct = 80;
	int unsigned   mismatches = 0;
	int unsigned   blocks_sent = 0;
	int unsigned   blocks_checked = 0;
	int unsigned   restarts_sent = 0;
	int unsigned   cycles = 0;

	aes128_cbc_encrypt uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #HalfPeriod clk = ~clk;

	function automatic logic [7:0] mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// AES-128 of one block; byte 0 is the top byte, round keys made as we go
	function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
			input logic [127:0] blk);
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [31:0] w [4];
		logic [31:0] g;
		logic [7:0] rc;
		logic [7:0] all;
		logic [127:0] res;
		rc = 8'h01;
		for (int i = 0; i < 4; i++)
			w[i] = key[127-32*i -: 32];
		for (int i = 0; i < 16; i++)
			st[i] = blk[127-8*i -: 8] ^ key[127-8*i -: 8];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			g = {SubTable[w[3][23:16]] ^ rc, SubTable[w[3][15:8]],
				SubTable[w[3][7:0]], SubTable[w[3][31:24]]};
			w[0] = w[0] ^ g;
			w[1] = w[1] ^ w[0];
			w[2] = w[2] ^ w[1];
			w[3] = w[3] ^ w[2];
			rc = mul2(rc);
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4*c+r] = SubTable[st[4*((c+r)%4)+r]];
			for (int c = 0; c < 4; c++) begin
				if (rnd < 10) begin
					all = tmp[4*c] ^ tmp[4*c+1] ^ tmp[4*c+2] ^ tmp[4*c+3];
					st[4*c]   = tmp[4*c]   ^ all ^ mul2(tmp[4*c]   ^ tmp[4*c+1]);
					st[4*c+1] = tmp[4*c+1] ^ all ^ mul2(tmp[4*c+1] ^ tmp[4*c+2]);
					st[4*c+2] = tmp[4*c+2] ^ all ^ mul2(tmp[4*c+2] ^ tmp[4*c+3]);
					st[4*c+3] = tmp[4*c+3] ^ all ^ mul2(tmp[4*c+3] ^ tmp[4*c]);
				end else begin
					for (int r = 0; r < 4; r++)
						st[4*c+r] = tmp[4*c+r];
				end
				for (int r = 0; r < 4; r++)
					st[4*c+r] = st[4*c+r] ^ w[c][31-8*r -: 8];
			end
		end
		for (int i = 0; i < 16; i++)
			res[127-8*i -: 8] = st[i];
		return res;
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				cipher_queue.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// register mirror, prediction on accepted requests, result check
	// tdata halves: high word of the block in the low half
	always @(posedge clk) begin
		logic [127:0] ct;
		logic [127:0] want;
		if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_HIGH: key_q[127:64] <= cfg_data;
				CFG_KEY_LOW:  key_q[63:0] <= cfg_data;
				CFG_IV_HIGH:  iv_q[127:64] <= cfg_data;
				CFG_IV_LOW:   iv_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready) begin
			ct = aes_encrypt(key_q, {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
				(s_axis_tuser ? iv_q : chain_q));
			chain_q <= ct;
			cipher_queue.push_back(ct);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (cipher_queue.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = cipher_queue.pop_front();
				blocks_checked++;
				if (m_axis_tdata[63:0] !== want[127:64] ||
						m_axis_tdata[127:64] !== want[63:0]) begin
					if (mismatches < 10)
						$display("result %0d: cipher_high %h/%h cipher_low %h/%h (exp/got)",
							blocks_checked, want[127:64], m_axis_tdata[63:0],
							want[63:0], m_axis_tdata[127:64]);
					mismatches++;
				end
			end
		end
	end

	// offer one block and hold it until taken, then maybe idle
	task automatic send_block(input logic [127:0] plain, input logic restart);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {plain[63:0], plain[127:64]};
		s_axis_tuser <= restart;
		do
			@(posedge clk);
		while (!s_axis_tready);
		blocks_sent++;
		if (restart)
			restarts_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	// let every outstanding block come back before touching registers
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (cipher_queue.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic load_regs(input logic [127:0] key, input logic [127:0] iv);
		logic [63:0] vals [4];
		vals = '{key[127:64], key[63:0], iv[127:64], iv[63:0]};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// plaintext with a bias towards extremes and single set bits
	function automatic logic [127:0] pick_plain();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 128'd1 << $urandom_range(127);
			default: return rand128();
		endcase
	endfunction

	step_t steps [$];

	initial begin
		logic [127:0] ones;
		ones = '1;
		// after reset: zero key, zero chain, zero IV
		steps.push_back('{0, 0, 0, 128'h0, 1'b0, 1,
			128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
		steps.push_back('{0, 0, 0, 128'h0, 1'b1, 1,
			128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
		steps.push_back('{0, 0, 0, ones, 1'b0, 0, 0});
		steps.push_back('{0, 0, 0, {8{16'h55aa}}, 1'b0, 0, 0});
		// standard test key, zero IV
		steps.push_back('{1, 128'h000102030405060708090a0b0c0d0e0f, 0, 0, 0, 0, 0});
		steps.push_back('{0, 0, 0, 128'h00112233445566778899aabbccddeeff, 1'b1, 1,
			128'h69c4e0d86a7b0430d8cdb78070b4c55a});
		steps.push_back('{0, 0, 0, 128'h00112233445566778899aabbccddeeff, 1'b0, 0, 0});
		steps.push_back('{0, 0, 0, ones, 1'b0, 0, 0});
		// all-ones key and IV
		steps.push_back('{1, ones, ones, 0, 0, 0, 0});
		steps.push_back('{0, 0, 0, 128'h0, 1'b0, 0, 0});
		steps.push_back('{0, 0, 0, ones, 1'b1, 0, 0});
		steps.push_back('{0, 0, 0, 128'h0, 1'b0, 0, 0});
		steps.push_back('{0, 0, 0, 128'h1, 1'b1, 0, 0});
		steps.push_back('{0, 0, 0, {1'b1, 127'h0}, 1'b0, 0, 0});
		// key zero again, odd IV, chain carried over
		steps.push_back('{1, 0, {8{16'hc3a5}}, 0, 0, 0, 0});
		steps.push_back('{0, 0, 0, {8{16'haa55}}, 1'b0, 0, 0});
		steps.push_back('{0, 0, 0, 128'h0, 1'b1, 0, 0});
		steps.push_back('{0, 0, 0, 128'h0, 1'b0, 0, 0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part; known answers are checked here on top of the predictor
		foreach (steps[i]) begin
			if (steps[i].is_setup) begin
				wait_idle();
				load_regs(steps[i].key, steps[i].iv);
			end else begin
				if (steps[i].known &&
						aes_encrypt(key_q, steps[i].plain ^
						(steps[i].restart ? iv_q : chain_q)) !== steps[i].cipher) begin
					$display("directed step %0d: predictor disagrees with known answer", i);
					mismatches++;
				end
				wait_idle();
				send_block(steps[i].plain, steps[i].restart);
			end
		end

		// random part in three idling phases, new keys every hundred or so
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 80 : 0;
			recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 11 : 0;
			for (int n = 0; n < RandomBlocks / 3; n++) begin
				if (n % 100 == 0) begin
					wait_idle();
					case ($urandom_range(3))
						0: load_regs('0, '1);
						1: load_regs('1, '0);
						default: load_regs(rand128(), rand128());
					endcase
				end
				send_block(pick_plain(), ($urandom_range(7) == 0));
			end
		end

		wait_idle();
		$display("%0d blocks sent (%0d chain restarts), %0d results checked",
			blocks_sent, restarts_sent, blocks_checked);
		$display("idling sender/receiver varied, keys and IVs incl. all-zero and all-ones");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/aes_pkg.sv
hdl/aes_column.sv
hdl/aes_round_seq.sv
hdl/aes128_cbc_encrypt.sv
test/aes128_cbc_encrypt_test.sv
